// ===== hw/rtl/aabq_pkg.sv =====
// aabq_pkg: shared types, codes and the entry overlap test for the blocker query block
// no dependencies; imported by aabq_qbox and the top module

package aabq_pkg;

    typedef logic signed [31:0] w32_t;    // Q16.16 coordinate as stored
    typedef logic signed [32:0] cell_t;   // exact world span / cell size
    typedef logic signed [43:0] prod_t;   // voxel index times cell
    typedef logic signed [44:0] q_t;      // full-width query coordinate
    typedef logic [9:0]         vidx_t;   // voxel index on one axis

    // one blocker table entry, min x in the lowest bits
    typedef struct packed {
        logic [31:0] section;
        w32_t        max_z;
        w32_t        max_y;
        w32_t        max_x;
        w32_t        min_z;
        w32_t        min_y;
        w32_t        min_x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [31:0] TAG_ANY = 32'hFFFF_FFFF;

    // deepest grid level that the voxel box builder honors
    localparam int DEPTH_CAP = 10;

    // request kinds carried in tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BOX   = 2'd1;
    localparam logic [1:0] REQ_VOXEL = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_WMIN_X = 3'd0;
    localparam logic [2:0] CFG_WMIN_Y = 3'd1;
    localparam logic [2:0] CFG_WMIN_Z = 3'd2;
    localparam logic [2:0] CFG_WMAX_X = 3'd3;
    localparam logic [2:0] CFG_WMAX_Y = 3'd4;
    localparam logic [2:0] CFG_WMAX_Z = 3'd5;
    localparam logic [2:0] CFG_DEPTH  = 3'd6;
    localparam logic [2:0] CFG_ACTIVE = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VOX,
        ST_SCAN,
        ST_RESULT
    } top_state_t;

    typedef enum logic [2:0] {
        VP_IDLE,
        VP_CELL,
        VP_MUL,
        VP_MIN,
        VP_MAX
    } vox_phase_t;

    // commands from the sequencer to the query box unit
    typedef struct packed {
        logic load_box;
        logic start_vox;
    } qb_cmd_t;

    // tag filter plus inclusive overlap on all three axes
    function automatic logic entry_hit(
        input entry_t      e,
        input logic [31:0] hint,
        input q_t          qmin_x,
        input q_t          qmin_y,
        input q_t          qmin_z,
        input q_t          qmax_x,
        input q_t          qmax_y,
        input q_t          qmax_z
    );
        logic tag_ok;
        logic apart;
        tag_ok = (hint == TAG_ANY) || (e.section == TAG_ANY) || (e.section == hint);
        apart  = (qmax_x < q_t'(e.min_x)) || (qmin_x > q_t'(e.max_x)) ||
                 (qmax_y < q_t'(e.min_y)) || (qmin_y > q_t'(e.max_y)) ||
                 (qmax_z < q_t'(e.min_z)) || (qmin_z > q_t'(e.max_z));
        return tag_ok && !apart;
    endfunction

endpackage

// ===== hw/rtl/aabq_ram.sv =====
// aabq_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module aabq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/aabq_qbox.sv =====
// aabq_qbox: query box registers and the shared voxel box builder
// one subtract/shift, multiply or add per cycle, one axis at a time; uses aabq_pkg

module aabq_qbox
    import aabq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qb_cmd_t    cmd,
    input  w32_t       wmin    [3],
    input  w32_t       wmax    [3],
    input  logic [3:0] depth,
    input  vidx_t      vidx    [3],
    input  w32_t       box_min [3],
    input  w32_t       box_max [3],
    output logic       done,
    output q_t         qmin    [3],
    output q_t         qmax    [3]
);

    vox_phase_t  phase_reg, phase_next;
    logic [1:0]  axis_reg, axis_next;
    cell_t       cell_reg, cell_next;
    prod_t       prod_reg, prod_next;
    q_t          qmin_reg [3];
    q_t          qmax_reg [3];
    vidx_t       vidx_reg [3];
    logic        last_axis;
    cell_t       span;
    logic signed [10:0] vx_s;

    assign last_axis = (axis_reg == 2'd2);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            VP_IDLE: if (cmd.start_vox) phase_next = VP_CELL;
            VP_CELL: phase_next = VP_MUL;
            VP_MUL:  phase_next = VP_MIN;
            VP_MIN:  phase_next = VP_MAX;
            VP_MAX:  phase_next = last_axis ? VP_IDLE : VP_CELL;
            default: phase_next = VP_IDLE;
        endcase
    end

    // phase outputs
    always_comb
    begin
        done      = 1'b0;
        axis_next = axis_reg;
        case (phase_reg)
            VP_IDLE: axis_next = 2'd0;
            VP_MAX:
            begin
                done      = last_axis;
                axis_next = last_axis ? 2'd0 : axis_reg + 2'd1;
            end
            default: axis_next = axis_reg;
        endcase
    end

    // shared datapath
    always_comb
    begin
        span      = cell_t'(wmax[axis_reg]) - cell_t'(wmin[axis_reg]);
        cell_next = (phase_reg == VP_CELL) ? (span >>> depth) : cell_reg;
        vx_s      = $signed({1'b0, vidx_reg[axis_reg]});
        prod_next = (phase_reg == VP_MUL) ? (vx_s * cell_reg) : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= VP_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        prod_reg <= prod_next;
        // voxel indexes are held for the whole build
        if (cmd.start_vox)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vidx_reg[k] <= vidx[k];
            end
        end
        if (cmd.load_box)
        begin
            for (int k = 0; k < 3; k++)
            begin
                qmin_reg[k] <= q_t'(box_min[k]);
                qmax_reg[k] <= q_t'(box_max[k]);
            end
        end
        else if (phase_reg == VP_MIN)
        begin
            qmin_reg[axis_reg] <= q_t'(wmin[axis_reg]) + q_t'(prod_reg);
        end
        else if (phase_reg == VP_MAX)
        begin
            qmax_reg[axis_reg] <= qmin_reg[axis_reg] + q_t'(cell_reg);
        end
    end

    assign qmin = qmin_reg;
    assign qmax = qmax_reg;

endmodule

// ===== hw/rtl/aabb_blocker_overlap_query_top.sv =====
// aabb_blocker_overlap_query_top: blocker box table with box and voxel overlap queries
// uses aabq_pkg, aabq_ram (entry table) and aabq_qbox (query box builder)
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata request fields
//  m_*      | out | m_tvalid/m_tready  | m_tdata[0] blocked
//  cfg_*    | in  | cfg_we             | cfg_index register, cfg_wdata value
//
// a write transaction goes from accept to the result state, then loads the result register
// a box query scans n = min(active_blockers, MAX_BLOCKERS) entries, and skips the scan when n is zero;
//   one entry per cycle is read from the entry RAM and compared, the scan stops early on a hit
// a voxel query first builds its box: the shared box builder spends four steps on each axis
// the block takes one transaction at a time; the result register frees the input side
//   as soon as the result is loaded, even while m_tready is low
// reset is asynchronous and clears control and configuration; the table is not cleared

module aabb_blocker_overlap_query_top
    import aabq_pkg::*;
#(
    parameter int MAX_BLOCKERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot[3:0], box_min_x/y/z, box_max_x/y/z, section_tag (32 each),
    // voxel_x/y/z (10 each), zero pad [263:258]
    input  logic [263:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // blocked[0], zero pad [7:1]
    output logic [7:0]   m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int AW = (MAX_BLOCKERS > 1) ? $clog2(MAX_BLOCKERS) : 1;
    localparam int CW = $clog2(MAX_BLOCKERS + 1);

    // configuration
    w32_t       wmin_reg [3];
    w32_t       wmax_reg [3];
    logic [3:0] depth_reg;
    logic [4:0] active_reg;

    // request fields
    logic [1:0]  in_req;
    logic [3:0]  in_slot;
    w32_t        in_min [3];
    w32_t        in_max [3];
    logic [31:0] in_tag;
    vidx_t       in_vidx [3];

    top_state_t  state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] n_sat;
    logic        pend_reg, pend_next;
    logic        last_reg, last_next;
    logic        hit_reg, hit_next;
    logic [31:0] hint_reg, hint_next;
    logic        m_valid_reg, m_valid_next;
    logic        blocked_reg, blocked_next;

    logic        accept;
    logic        slot_ok;
    logic        issue;
    logic        scan_hit;
    logic        scan_end;
    logic        out_free;
    logic        out_load;
    logic        ram_we;
    logic [3:0]  depth_sat;

    qb_cmd_t     qb_cmd;
    logic        vox_done;
    q_t          qmin [3];
    q_t          qmax [3];

    entry_t            wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    // payload unpack
    assign in_req     = s_tuser;
    assign in_slot    = s_tdata[3:0];
    assign in_min[0]  = s_tdata[35:4];
    assign in_min[1]  = s_tdata[67:36];
    assign in_min[2]  = s_tdata[99:68];
    assign in_max[0]  = s_tdata[131:100];
    assign in_max[1]  = s_tdata[163:132];
    assign in_max[2]  = s_tdata[195:164];
    assign in_tag     = s_tdata[227:196];
    assign in_vidx[0] = s_tdata[237:228];
    assign in_vidx[1] = s_tdata[247:238];
    assign in_vidx[2] = s_tdata[257:248];

    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = (32'(in_slot) < MAX_BLOCKERS);
    assign n_sat    = (32'(active_reg) > MAX_BLOCKERS) ? CW'(MAX_BLOCKERS) : CW'(active_reg);
    assign depth_sat = (32'(depth_reg) > DEPTH_CAP) ? 4'(DEPTH_CAP) : depth_reg;
    assign out_free = !m_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wmin_reg[k] <= '0;
                wmax_reg[k] <= '0;
            end
            depth_reg  <= '0;
            active_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WMIN_X: wmin_reg[0] <= cfg_wdata;
                CFG_WMIN_Y: wmin_reg[1] <= cfg_wdata;
                CFG_WMIN_Z: wmin_reg[2] <= cfg_wdata;
                CFG_WMAX_X: wmax_reg[0] <= cfg_wdata;
                CFG_WMAX_Y: wmax_reg[1] <= cfg_wdata;
                CFG_WMAX_Z: wmax_reg[2] <= cfg_wdata;
                CFG_DEPTH:  depth_reg   <= cfg_wdata[3:0];
                CFG_ACTIVE: active_reg  <= cfg_wdata[4:0];
                default:    active_reg  <= active_reg;
            endcase
        end
    end

    // entry table
    assign wr_entry = '{section: in_tag,
                        max_z: in_max[2], max_y: in_max[1], max_x: in_max[0],
                        min_z: in_min[2], min_y: in_min[1], min_x: in_min[0]};

    aabq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_slot)),
        .wdata (wr_entry),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // query box: loaded for box queries, built per axis for voxel queries
    aabq_qbox u_qbox (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (qb_cmd),
        .wmin    (wmin_reg),
        .wmax    (wmax_reg),
        .depth   (depth_sat),
        .vidx    (in_vidx),
        .box_min (in_min),
        .box_max (in_max),
        .done    (vox_done),
        .qmin    (qmin),
        .qmax    (qmax)
    );

    // compare of the entry read in the previous cycle
    assign scan_hit = pend_reg && entry_hit(rd_entry, hint_reg, qmin[0], qmin[1], qmin[2],
                                            qmax[0], qmax[1], qmax[2]);
    assign scan_end = scan_hit || (pend_reg && last_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_req)
                        REQ_BOX:   state_next = (n_sat == '0) ? ST_RESULT : ST_SCAN;
                        REQ_VOXEL: state_next = ST_VOX;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_VOX:    if (vox_done) state_next = (n_reg == '0) ? ST_RESULT : ST_SCAN;
            ST_SCAN:   if (scan_end) state_next = ST_RESULT;
            ST_RESULT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE);
        qb_cmd.load_box  = accept && (in_req == REQ_BOX);
        qb_cmd.start_vox = accept && (in_req == REQ_VOXEL);
        ram_we           = accept && (in_req == REQ_WRITE) && slot_ok;
        issue            = (state_reg == ST_SCAN) && (idx_reg != n_reg);
        out_load         = (state_reg == ST_RESULT) && out_free;
    end

    // datapath next values
    always_comb
    begin
        idx_next  = (state_reg == ST_SCAN && issue) ? CW'(idx_reg + 1'b1) :
                    (state_reg == ST_SCAN) ? idx_reg : '0;
        pend_next = issue;
        last_next = issue && (CW'(idx_reg + 1'b1) == n_reg);
        n_next    = accept ? n_sat : n_reg;
        hint_next = accept ? ((in_req == REQ_BOX) ? in_tag : TAG_ANY) : hint_reg;
        if (state_reg == ST_IDLE)
            hit_next = 1'b0;
        else if (state_reg == ST_SCAN && scan_hit)
            hit_next = 1'b1;
        else
            hit_next = hit_reg;
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        blocked_next = out_load ? hit_reg : blocked_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            n_reg       <= '0;
            pend_reg    <= 1'b0;
            last_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            pend_reg    <= pend_next;
            last_reg    <= last_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hint_reg    <= hint_next;
        blocked_reg <= blocked_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, blocked_reg};

    // checks

    // a table write always goes straight to the result
    a_write_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_req == REQ_WRITE) |=> (state_reg == ST_RESULT))
        else $error("write transaction did not go to result");

    // a new result only appears after the result step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(m_valid_reg) && m_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result valid without result step");

    // the scan index never runs past the tested count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= n_reg && 32'(n_reg) <= MAX_BLOCKERS))
        else $error("scan index beyond active entries");

    // a finished voxel box leads into the scan or the result
    a_vox_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VOX && vox_done) |=> (state_reg == ST_SCAN || state_reg == ST_RESULT))
        else $error("voxel build did not hand over");

endmodule

// ===== bench/aabb_blocker_overlap_query_top_tb.sv =====
// self-checking bench for aabb_blocker_overlap_query_top: writes, box queries and voxel
// queries on the blocker table, predicted in the bench and checked per result transaction
// depends on aabq_pkg and the block's rtl only

module aabb_blocker_overlap_query_top_tb;

    import aabq_pkg::*;

    localparam int TBL          = 16;        // table entries in the block
    localparam int UNIT         = 1 << 16;   // 1.0 in Q16.16
    localparam int HOLD_CYCLES  = 200;       // long receiver hold-off
    localparam int STALL_LIMIT  = 3000;      // cycles with no transaction before giving up
    localparam int TAIL_CYCLES  = 40;        // beyond the slowest voxel query

    // one request transaction, unpacked form
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] min_z;
        logic [31:0] max_x;
        logic [31:0] max_y;
        logic [31:0] max_z;
        logic [31:0] tag;
        logic [9:0]  vx;
        logic [9:0]  vy;
        logic [9:0]  vz;
    } req_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_we    = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    // bench copy of the configuration and the blocker table
    logic signed [31:0] grid_min [3];
    logic signed [31:0] grid_max [3];
    logic [3:0]         cfg_depth  = '0;
    logic [4:0]         cfg_active = '0;
    logic signed [31:0] ent_lo [TBL][3];
    logic signed [31:0] ent_hi [TBL][3];
    logic [31:0]        ent_tag [TBL];

    req_t req_q [$];        // requests waiting for the driver
    logic blocked_q [$];    // expected blocked flags, oldest first
    req_t cur_req;

    int  posted_reqs   = 0;
    int  accepted_reqs = 0;
    int  taken_results = 0;
    int  error_cnt     = 0;
    int  stall_cycles  = 0;
    bit  calm          = 1'b0;  // no idling on either side
    bit  hold_req      = 1'b0;  // ask the receiver for one long hold-off

    always #5 clk = ~clk;

    aabb_blocker_overlap_query_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    task automatic flag_error(input string msg);
        $display("mismatch at result %0d: %s", taken_results, msg);
        error_cnt++;
    endtask

    // expected blocked flag for one request; writes update the table copy
    function automatic logic predict_blocked(input req_t r);
        longint      lo [3];
        longint      hi [3];
        logic [9:0]  vox [3];
        logic [31:0] hint;
        longint      csize;
        int          n;
        int          dsat;
        logic        apart;
        logic        hit;
        hit    = 1'b0;
        hint   = TAG_ANY;
        vox[0] = r.vx;
        vox[1] = r.vy;
        vox[2] = r.vz;
        lo[0]  = longint'($signed(r.min_x));
        lo[1]  = longint'($signed(r.min_y));
        lo[2]  = longint'($signed(r.min_z));
        hi[0]  = longint'($signed(r.max_x));
        hi[1]  = longint'($signed(r.max_y));
        hi[2]  = longint'($signed(r.max_z));
        if (r.kind == REQ_WRITE)
        begin
            ent_lo[r.slot][0] = r.min_x;
            ent_lo[r.slot][1] = r.min_y;
            ent_lo[r.slot][2] = r.min_z;
            ent_hi[r.slot][0] = r.max_x;
            ent_hi[r.slot][1] = r.max_y;
            ent_hi[r.slot][2] = r.max_z;
            ent_tag[r.slot]   = r.tag;
        end
        else if (r.kind == REQ_BOX || r.kind == REQ_VOXEL)
        begin
            if (r.kind == REQ_BOX)
                hint = r.tag;
            else
            begin
                // voxel box at the configured depth capped at DEPTH_CAP, exact width, floor shift of the span
                dsat = (int'(cfg_depth) > DEPTH_CAP) ? DEPTH_CAP : int'(cfg_depth);
                for (int k = 0; k < 3; k++)
                begin
                    csize = (longint'(grid_max[k]) - longint'(grid_min[k])) >>> dsat;
                    lo[k] = longint'(grid_min[k]) + longint'(vox[k]) * csize;
                    hi[k] = lo[k] + csize;
                end
            end
            n = (int'(cfg_active) > TBL) ? TBL : int'(cfg_active);
            for (int i = 0; i < n; i++)
            begin
                if (hint == TAG_ANY || ent_tag[i] == TAG_ANY || ent_tag[i] == hint)
                begin
                    // touching faces still overlap
                    apart = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (hi[k] < longint'(ent_lo[i][k]) || lo[k] > longint'(ent_hi[i][k]))
                            apart = 1'b1;
                    end
                    if (!apart)
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // one axis span: mostly grid-aligned boxes near the origin so faces meet often
    function automatic void rand_span(output logic [31:0] lo, output logic [31:0] hi);
        int c;
        int half;
        int pick;
        pick = $urandom_range(0, 19);
        c    = (int'($urandom_range(0, 128)) - 64) * UNIT;
        half = int'($urandom_range(0, 16)) * UNIT;
        lo   = c - half;
        hi   = c + half;
        if (pick == 0)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (pick == 1)
            lo = 32'h8000_0000;
        else if (pick == 2)
            hi = 32'h7FFF_FFFF;
        else if (pick == 3)
        begin
            // inverted span
            lo = c + half + UNIT;
            hi = c - half;
        end
        else if (pick == 4)
            hi = c + half - 1;
    endfunction

    // voxel index: mostly inside the grid, sometimes anywhere in the field
    function automatic logic [9:0] pick_index(input int dsat);
        if ($urandom_range(0, 7) == 0)
            return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, (1 << dsat) - 1));
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   pick;
        int   dsat;
        pick   = $urandom_range(0, 19);
        r.kind = (pick < 7) ? REQ_WRITE : (pick < 14) ? REQ_BOX :
                 (pick < 19) ? REQ_VOXEL : REQ_NONE;
        r.slot = 4'($urandom_range(0, TBL - 1));
        rand_span(r.min_x, r.max_x);
        rand_span(r.min_y, r.max_y);
        rand_span(r.min_z, r.max_z);
        case ($urandom_range(0, 5))
            0:       r.tag = TAG_ANY;
            4:       r.tag = $urandom;
            default: r.tag = 32'($urandom_range(1, 3));
        endcase
        dsat = (int'(cfg_depth) > DEPTH_CAP) ? DEPTH_CAP : int'(cfg_depth);
        r.vx = pick_index(dsat);
        r.vy = pick_index(dsat);
        r.vz = pick_index(dsat);
        return r;
    endfunction

    // same span on all three axes
    function automatic req_t cube(input logic [1:0] kind, input logic [3:0] slot,
                                  input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [31:0] tag);
        req_t r;
        r       = rand_req();
        r.kind  = kind;
        r.slot  = slot;
        r.min_x = lo;
        r.min_y = lo;
        r.min_z = lo;
        r.max_x = hi;
        r.max_y = hi;
        r.max_z = hi;
        r.tag   = tag;
        return r;
    endfunction

    task automatic post(input req_t r);
        req_q.push_back(r);
        posted_reqs++;
    endtask

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            post(rand_req());
    endtask

    // sender pause: every request taken and every result back
    task automatic wait_idle();
        while (accepted_reqs != posted_reqs || blocked_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx <= CFG_WMIN_Z)
            grid_min[idx] = val;
        else if (idx <= CFG_WMAX_Z)
            grid_max[idx - CFG_WMAX_X] = val;
        else if (idx == CFG_DEPTH)
            cfg_depth = val[3:0];
        else
            cfg_active = val[4:0];
    endtask

    task automatic set_grid(input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] z0, input logic [31:0] x1,
                            input logic [31:0] y1, input logic [31:0] z1,
                            input logic [3:0] depth, input logic [4:0] active);
        cfg_write(CFG_WMIN_X, x0);
        cfg_write(CFG_WMIN_Y, y0);
        cfg_write(CFG_WMIN_Z, z0);
        cfg_write(CFG_WMAX_X, x1);
        cfg_write(CFG_WMAX_Y, y1);
        cfg_write(CFG_WMAX_Z, z1);
        cfg_write(CFG_DEPTH, 32'(depth));
        cfg_write(CFG_ACTIVE, 32'(active));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver: one transaction at a time, random gap after each
    int sent_cnt = 0;
    int send_gap = 0;
    always @(negedge clk)
    begin
        logic nv;
        nv = s_tvalid;
        if (!rst_n)
            nv = 1'b0;
        else
        begin
            if (s_tvalid && accepted_reqs != sent_cnt)
            begin
                sent_cnt = accepted_reqs;
                nv       = 1'b0;
                send_gap = calm ? 0 : $urandom_range(0, 8);
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (req_q.size() > 0)
                begin
                    cur_req = req_q.pop_front();
                    s_tdata <= {6'd0, cur_req.vz, cur_req.vy, cur_req.vx, cur_req.tag,
                                cur_req.max_z, cur_req.max_y, cur_req.max_x,
                                cur_req.min_z, cur_req.min_y, cur_req.min_x, cur_req.slot};
                    s_tuser <= cur_req.kind;
                    nv = 1'b1;
                end
            end
        end
        s_tvalid <= nv;
    end

    // result receiver: random hold-off after each transaction, one long hold on request
    int  seen_results = 0;
    int  ready_gap    = 0;
    bit  hold_done    = 1'b0;
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (taken_results != seen_results)
            begin
                seen_results = taken_results;
                if (hold_req && !hold_done)
                begin
                    ready_gap = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                else
                    ready_gap = calm ? 0 : $urandom_range(0, 8);
            end
            if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: predict on request transactions, check on result transactions
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                blocked_q.push_back(predict_blocked(cur_req));
                accepted_reqs++;
            end
            if (m_tvalid && m_tready)
            begin
                taken_results++;
                if (blocked_q.size() == 0)
                    flag_error($sformatf("blocked=%0b with nothing outstanding", m_tdata[0]));
                else
                begin
                    want = blocked_q.pop_front();
                    if (m_tdata[0] !== want)
                        flag_error($sformatf("blocked=%0b, want %0b", m_tdata[0], want));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        req_t r;
        for (int k = 0; k < 3; k++)
        begin
            grid_min[k] = '0;
            grid_max[k] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: no active entries, nothing can block
        post(cube(REQ_BOX, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, TAG_ANY));
        r    = cube(REQ_VOXEL, 4'd0, '0, '0, '0);
        r.vx = '0;
        r.vy = '0;
        r.vz = '0;
        post(r);
        post(cube(REQ_NONE, 4'd15, '0, '0, '0));

        // fill the whole table before any entry is tested
        post(cube(REQ_WRITE, 4'd0, '0, 10 * UNIT, 32'd7));
        post(cube(REQ_WRITE, 4'd1, 20 * UNIT, 30 * UNIT, TAG_ANY));
        for (int s = 2; s < TBL - 1; s++)
        begin
            r      = rand_req();
            r.kind = REQ_WRITE;
            r.slot = 4'(s);
            post(r);
        end
        post(cube(REQ_WRITE, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_C3C3));
        wait_idle();

        // directed checks against the two known entries
        set_grid(-64 * UNIT, -64 * UNIT, -64 * UNIT, 64 * UNIT, 64 * UNIT, 64 * UNIT,
                 4'd3, 5'd2);
        post(cube(REQ_BOX, 4'd0, 10 * UNIT, 20 * UNIT, 32'd7));        // faces touch
        post(cube(REQ_BOX, 4'd0, 10 * UNIT + 1, 19 * UNIT, 32'd7));    // one lsb clear
        post(cube(REQ_BOX, 4'd0, 2 * UNIT, 5 * UNIT, 32'd3));          // tag mismatch
        post(cube(REQ_BOX, 4'd0, 2 * UNIT, 5 * UNIT, TAG_ANY));        // wildcard hint
        post(cube(REQ_BOX, 4'd0, 20 * UNIT, '0, 32'd7));               // inverted query
        r    = cube(REQ_VOXEL, 4'd0, '0, '0, '0);
        r.vx = 10'd4;
        r.vy = 10'd4;
        r.vz = 10'd4;
        post(r);
        r.vx = 10'd1023;                                               // beyond the grid
        r.vy = 10'd1023;
        r.vz = 10'd1023;
        post(r);
        post(cube(REQ_NONE, 4'd3, 2 * UNIT, 5 * UNIT, TAG_ANY));
        wait_idle();

        // random phases, each under its own configuration
        set_grid(-64 * UNIT, -64 * UNIT, -64 * UNIT, 64 * UNIT, 64 * UNIT, 64 * UNIT,
                 4'd3, 5'd16);
        random_burst(70);
        wait_idle();

        // widest world, depth and count past their limits
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, 5'd31);
        random_burst(60);
        wait_idle();

        // inverted world bounds give negative cells
        set_grid(64 * UNIT, 64 * UNIT, 64 * UNIT, -64 * UNIT, -64 * UNIT, -64 * UNIT,
                 4'd10, 5'd7);
        random_burst(60);
        wait_idle();

        // back-to-back transactions with no idling
        calm = 1'b1;
        set_grid(-64 * UNIT, '0, -8 * UNIT, 64 * UNIT, 32 * UNIT, 120 * UNIT, 4'd5, 5'd16);
        random_burst(70);
        wait_idle();
        calm = 1'b0;

        // receiver holds off while requests keep coming
        set_grid(-64 * UNIT, -64 * UNIT, -64 * UNIT, 64 * UNIT, 64 * UNIT, 64 * UNIT,
                 4'd1, 5'd12);
        hold_req = 1'b1;
        random_burst(70);
        wait_idle();

        set_grid('0, '0, '0, '0, '0, '0, 4'd0, 5'd0);
        random_burst(20);
        wait_idle();

        set_grid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
        random_burst(60);
        wait_idle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (blocked_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", blocked_q.size()));
        if (error_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
